// File: hdl/linear_probe_hash_map_top_assert.svh
// assertion macros for the hash map
`ifndef LINEAR_PROBE_HASH_MAP_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LPHM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash map check failed");

// next-cycle implication, checked outside reset
`define LPHM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash map check failed");

`endif

// File: hdl/lphm_pkg.sv
`default_nettype none
package lphm_pkg;

    // fmix64 multiplier constants, split in halves
    localparam logic [31:0] MIX_C1_LO = 32'hed558ccd;
    localparam logic [31:0] MIX_C1_HI = 32'hff51afd7;
    localparam logic [31:0] MIX_C2_LO = 32'h1a85ec53;
    localparam logic [31:0] MIX_C2_HI = 32'hc4ceb9fe;

    // fill limit fraction
    localparam int FILL_NUM = 3;
    localparam int FILL_DEN = 4;

    typedef enum logic [2:0] {
        ST_MISS     = 3'd0,
        ST_HIT      = 3'd1,
        ST_INSERTED = 3'd2,
        ST_SAME     = 3'd3,
        ST_CONFLICT = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_XS,
        S_MOD,
        S_QUO,
        S_REM,
        S_FIX,
        S_RD,
        S_CHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [31:0] addr;
        logic [63:0] eid_in;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [63:0] eid_out;
        logic [10:0] entry_count;
        logic [31:0] collision_total;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] id;
    } t_slot;

endpackage
`default_nettype wire

// File: hdl/linear_probe_hash_map_top.sv
// Hash map from 32-bit addresses to 64-bit ids, open addressing, linear probing.
// Input channel: i_valid / o_stall carry a request word i_req (lookup or insert).
// Output channel: o_valid / i_stall carry one response word o_rsp per request.
// A word moves at a rising edge with valid high and stall low.
// After reset the table is cleared one slot a cycle, with o_stall held high;
// the counters restart at zero.
// Per request: an accept state, then hashing on one shared 32x32 multiplier
// (two rounds of three partial products and a xor-shift), plus a reduction
// when TABLE_SLOTS is not a power of two (four folds by 2^32 mod
// TABLE_SLOTS, a reciprocal quotient, a remainder, a correction), then a
// registered memory read and a check per probed slot, then a state that
// registers the response.
// One request is in work at a time; the next is taken as soon as the
// response sits in the output register, even while the receiver stalls it.
// A stalled response holds; a finished request waits for the output
// register to free before its response is loaded.
`default_nettype none
module linear_probe_hash_map_top
    import lphm_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    `include "linear_probe_hash_map_top_assert.svh"

    localparam int IW     = $clog2(TABLE_SLOTS);
    localparam int CW     = $clog2(TABLE_SLOTS + 1);
    localparam int LIMIT  = (TABLE_SLOTS * FILL_NUM) / FILL_DEN;
    localparam bit IS_POW2 = ((1 << IW) == TABLE_SLOTS);
    // reduction constants
    localparam logic [63:0] TWO_POW32 = 64'h1_0000_0000;
    localparam logic [31:0] FOLD_R    = 32'(TWO_POW32 % TABLE_SLOTS);
    localparam logic [31:0] RECIP     = 32'(TWO_POW32 / TABLE_SLOTS);

    // table memory
    t_slot mem [TABLE_SLOTS];
    t_slot r_rd;
    logic            mem_we;
    logic [IW-1:0]   mem_wa;
    t_slot           mem_wd;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [63:0] r_k, n_k;
    logic [63:0] r_acc, n_acc;
    logic        r_round, n_round;
    logic [IW:0] r_rem, n_rem;
    logic [1:0]  r_bit, n_bit;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_steps, n_steps;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_coll, n_coll;
    t_rsp  r_res, n_res;
    logic  r_ovalid, n_ovalid;
    t_rsp  r_orsp, n_orsp;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] xs;
    logic [31:0] rem_w;
    logic [IW:0] rem_fix;
    logic [32:0] coll_sum;
    logic        out_free;

    // shared multiplier
    assign mul_p    = {32'b0, mul_a} * {32'b0, mul_b};
    assign xs       = r_acc ^ (r_acc >> 33);
    assign rem_w    = r_k[31:0] - mul_p[31:0];
    assign rem_fix  = r_rem - (IW+1)'(TABLE_SLOTS);
    assign coll_sum = {1'b0, r_coll} + 33'(r_steps);
    assign out_free = !r_ovalid || !i_stall;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_idx];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_count  <= '0;
            r_coll   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_coll   <= n_coll;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_round <= n_round;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_steps <= n_steps;
        r_res   <= n_res;
        r_orsp  <= n_orsp;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_k      = r_k;
        n_acc    = r_acc;
        n_round  = r_round;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_idx    = r_idx;
        n_steps  = r_steps;
        n_count  = r_count;
        n_coll   = r_coll;
        n_res    = r_res;
        n_ovalid = r_ovalid && i_stall;
        n_orsp   = r_orsp;
        mul_a    = r_k[31:0];
        mul_b    = MIX_C1_LO;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = '0;
        o_stall  = (r_state != S_IDLE);

        case (r_state)
            // clearing pass after reset
            S_CLR: begin
                mem_we = 1'b1;
                if (r_idx == IW'(TABLE_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req;
                    n_k     = {32'b0, i_req.addr};
                    n_round = 1'b0;
                    n_state = S_MUL0;
                end
            end
            // 64x64 low product from three partial products
            S_MUL0: begin
                mul_a   = r_k[31:0];
                mul_b   = r_round ? MIX_C2_LO : MIX_C1_LO;
                n_acc   = mul_p;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                mul_a   = r_k[31:0];
                mul_b   = r_round ? MIX_C2_HI : MIX_C1_HI;
                n_acc   = r_acc + {mul_p[31:0], 32'b0};
                n_state = S_MUL2;
            end
            S_MUL2: begin
                mul_a   = r_k[63:32];
                mul_b   = r_round ? MIX_C2_LO : MIX_C1_LO;
                n_acc   = r_acc + {mul_p[31:0], 32'b0};
                n_state = S_XS;
            end
            S_XS: begin
                n_k = xs;
                if (!r_round) begin
                    n_round = 1'b1;
                    n_state = S_MUL0;
                end else begin
                    n_steps = '0;
                    if (IS_POW2) begin
                        n_idx   = xs[IW-1:0];
                        n_state = S_RD;
                    end else begin
                        n_bit   = '0;
                        n_state = S_MOD;
                    end
                end
            end
            // fold the upper half down by 2^32 mod slots, four times
            S_MOD: begin
                mul_a = r_k[63:32];
                mul_b = FOLD_R;
                n_k   = mul_p + {32'b0, r_k[31:0]};
                n_bit = r_bit + 1'b1;
                if (r_bit == 2'd3) begin
                    n_state = S_QUO;
                end
            end
            // quotient estimate by reciprocal, at most one short
            S_QUO: begin
                mul_a   = r_k[31:0];
                mul_b   = RECIP;
                n_acc   = {32'b0, mul_p[63:32]};
                n_state = S_REM;
            end
            S_REM: begin
                mul_a   = r_acc[31:0];
                mul_b   = 32'(TABLE_SLOTS);
                n_rem   = rem_w[IW:0];
                n_state = S_FIX;
            end
            // one correcting subtract
            S_FIX: begin
                if (r_rem >= (IW+1)'(TABLE_SLOTS)) begin
                    n_idx = rem_fix[IW-1:0];
                end else begin
                    n_idx = r_rem[IW-1:0];
                end
                n_state = S_RD;
            end
            // wait for the slot read
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_res.eid_out = '0;
                n_state       = S_OUT;
                if (r_steps == CW'(TABLE_SLOTS)) begin
                    n_res.status = r_req.req_type ? ST_FULL : ST_MISS;
                end else if (!r_rd.valid) begin
                    if (!r_req.req_type) begin
                        n_res.status = ST_MISS;
                    end else if (r_count >= CW'(LIMIT)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        mem_we       = 1'b1;
                        mem_wd.valid = 1'b1;
                        mem_wd.key   = r_req.addr;
                        mem_wd.id    = r_req.eid_in;
                        n_count      = r_count + 1'b1;
                        n_coll       = coll_sum[32] ? '1 : coll_sum[31:0];
                        n_res.status = ST_INSERTED;
                    end
                end else if (r_rd.key == r_req.addr) begin
                    if (!r_req.req_type) begin
                        n_res.status  = ST_HIT;
                        n_res.eid_out = r_rd.id;
                    end else if (r_rd.id == r_req.eid_in) begin
                        n_res.status = ST_SAME;
                    end else begin
                        n_res.status = ST_CONFLICT;
                    end
                end else begin
                    // step to next slot with wraparound
                    n_steps = r_steps + 1'b1;
                    n_idx   = (r_idx == IW'(TABLE_SLOTS - 1)) ? '0 : r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            // load response word when output register frees
            S_OUT: begin
                if (out_free) begin
                    n_orsp                 = r_res;
                    n_orsp.entry_count     = 11'(r_count);
                    n_orsp.collision_total = r_coll;
                    n_ovalid               = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_orsp;

    `LPHM_ASSERT_NOW(a_count_limit, 1'b1, r_count <= CW'(LIMIT))
    `LPHM_ASSERT_NEXT(a_one_in_work, i_valid && !o_stall, o_stall)
    `LPHM_ASSERT_NEXT(a_insert_counts, mem_we && r_state == S_CHK,
        r_count == $past(r_count) + 1'b1)
    `LPHM_ASSERT_NOW(a_eid_only_hit, o_valid && o_rsp.status != ST_HIT,
        o_rsp.eid_out == 64'd0)

endmodule
`default_nettype wire
